/* hw/rtl/sddv_pkg.sv */
// Shared constants for the stereo disparity to depth vertex block.
`default_nettype none
package sddv_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_EYE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_EYE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FOCAL      = 3'd2;
  localparam logic [2:0] REG_BASELINE   = 3'd3;
  localparam logic [2:0] REG_DISP_BIAS  = 3'd4;
  localparam logic [2:0] REG_MIN_DISP   = 3'd5;
  localparam logic [2:0] REG_NEAR       = 3'd6;
  localparam logic [2:0] REG_FAR        = 3'd7;

  // Register reset values
  localparam logic [10:0] RST_EYE_WIDTH  = 11'd384;
  localparam logic [10:0] RST_EYE_HEIGHT = 11'd224;
  localparam logic [15:0] RST_FOCAL      = 16'd6400;
  localparam logic [15:0] RST_BASELINE   = 16'd4194;
  localparam logic [15:0] RST_DISP_BIAS  = 16'd0;
  localparam logic [15:0] RST_MIN_DISP   = 16'd1;
  localparam logic [23:0] RST_NEAR       = 24'd6554;
  localparam logic [23:0] RST_FAR        = 24'd655360;

  // Shared divider geometry
  localparam int DIV_NW = 42;  // numerator and quotient bits
  localparam int DIV_DW = 37;  // divisor and remainder bits
  localparam int DIV_CW = 6;   // step counter bits

endpackage
`default_nettype wire

/* hw/rtl/stereo_disparity_depth_vertex.sv */
// Stereo disparity to depth vertex: top level with sequencer and shared divider.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one mesh vertex: pixel position,
//   left/right eye positions here and at the next grid column, valid flags.
//   Output channel (out_valid_o/out_ready_i) returns one item per vertex:
//   back-projected position (pos_x/y/z) and texture coordinates (tex_u/v).
//   Configuration port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
//   always ready; write it only while the block is idle.
//   Up to six rounded divisions run per item; a degenerate tangent, an unusable
//   disparity or a zero focal length skip divisions. Each division runs on the
//   one radix-2 restoring divider: a load state, 42 steps and a hand-over.
//   Further states go to geometry, products, sums, clamps and output.
//   One item is in work at a time; the input reopens in the cycle after the
//   result is written, so a new vertex is taken only once the last is through.
//   The finished item sits in the output register, so the next vertex is
//   taken while it waits; a stalled receiver holds the block only once the
//   next item is finished as well.
//   Reset clears the configuration to its defaults, the held disparity to
//   zero and empties the output register.
`default_nettype none
module stereo_disparity_depth_vertex
  import sddv_pkg::*;
#(
  parameter int BASE_DISTANCE = 65536,
  parameter int MAX_EYE_DIM   = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [2:0]         cfg_index_i,
  input  wire  [23:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                frame_start_i,
  input  wire  [9:0]         pixel_x_i,
  input  wire  [9:0]         pixel_y_i,
  input  wire  signed [15:0] left_x_i,
  input  wire  signed [15:0] left_y_i,
  input  wire  signed [15:0] right_x_i,
  input  wire  signed [15:0] right_y_i,
  input  wire  signed [15:0] next_left_x_i,
  input  wire  signed [15:0] next_left_y_i,
  input  wire  signed [15:0] next_right_x_i,
  input  wire  signed [15:0] next_right_y_i,
  input  wire  [1:0]         valid_flags_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o
);

  localparam logic [12:0] MAX_DIM = 13'(MAX_EYE_DIM);
  localparam logic [31:0] BASE_D  = 32'(BASE_DISTANCE);

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_GEOM = 5'd1;
  localparam logic [4:0] S_PROD = 5'd2;
  localparam logic [4:0] S_SUM  = 5'd3;
  localparam logic [4:0] S_DL   = 5'd4;
  localparam logic [4:0] S_DW   = 5'd5;
  localparam logic [4:0] S_DEP  = 5'd6;
  localparam logic [4:0] S_ZL   = 5'd7;
  localparam logic [4:0] S_ZW   = 5'd8;
  localparam logic [4:0] S_ZC   = 5'd9;
  localparam logic [4:0] S_XYM  = 5'd10;
  localparam logic [4:0] S_XL   = 5'd11;
  localparam logic [4:0] S_XW   = 5'd12;
  localparam logic [4:0] S_YL   = 5'd13;
  localparam logic [4:0] S_YW   = 5'd14;
  localparam logic [4:0] S_UL   = 5'd15;
  localparam logic [4:0] S_UW   = 5'd16;
  localparam logic [4:0] S_VL   = 5'd17;
  localparam logic [4:0] S_VW   = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  // Configuration registers
  logic [10:0] eye_w_q, eye_h_q;
  logic [15:0] focal_q, base_q, min_disp_q;
  logic signed [15:0] bias_q;
  logic [23:0] near_q, far_q;

  // Captured item
  logic        fs_q;
  logic [9:0]  pix_x_q, pix_y_q;
  logic signed [15:0] lx_q, ly_q, rx_q, ry_q, nlx_q, nly_q, nrx_q, nry_q;
  logic [1:0]  vf_q;

  // Working registers
  logic [4:0]  state_q;
  logic [9:0]  pxc_q, pyc_q;
  logic [10:0] wm1_q, hm1_q;
  logic signed [17:0] tx_q, ty_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [35:0] pxx_q, pyy_q, pxd_q, pyd_q;
  logic [31:0] fb_q;
  logic [35:0] den_q;
  logic signed [35:0] num_q;
  logic signed [31:0] held_q;
  logic [32:0] ad_q;
  logic [23:0] z_q;
  logic [35:0] mx_q, my_q;
  logic        xneg_q, yneg_q;
  logic signed [31:0] res_x_q, res_y_q;
  logic [16:0] res_u_q, res_v_q;

  // Divider
  logic [DIV_NW-1:0] dvn_q;
  logic [DIV_DW-1:0] dvr_q, dvd_q;
  logic [DIV_CW-1:0] dcnt_q;
  logic              dneg_q;

  logic out_valid_q;

  function automatic logic signed [31:0] sat_q(input logic neg, input logic [DIV_NW-1:0] q);
    logic [DIV_NW-1:0] neg_q;
    neg_q = '0 - q;
    if (!neg) begin
      sat_q = (q > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(q[31:0]);
    end else begin
      sat_q = (q > DIV_NW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : signed'(neg_q[31:0]);
    end
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_w_q    <= RST_EYE_WIDTH;
      eye_h_q    <= RST_EYE_HEIGHT;
      focal_q    <= RST_FOCAL;
      base_q     <= RST_BASELINE;
      bias_q     <= signed'(RST_DISP_BIAS);
      min_disp_q <= RST_MIN_DISP;
      near_q     <= RST_NEAR;
      far_q      <= RST_FAR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EYE_WIDTH:  eye_w_q    <= cfg_data_i[10:0];
        REG_EYE_HEIGHT: eye_h_q    <= cfg_data_i[10:0];
        REG_FOCAL:      focal_q    <= cfg_data_i[15:0];
        REG_BASELINE:   base_q     <= cfg_data_i[15:0];
        REG_DISP_BIAS:  bias_q     <= signed'(cfg_data_i[15:0]);
        REG_MIN_DISP:   min_disp_q <= cfg_data_i[15:0];
        REG_NEAR:       near_q     <= cfg_data_i[23:0];
        REG_FAR:        far_q      <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Geometry: clamp sizes and pixel, apply fallbacks, form tangent and eye difference
  logic [12:0] w_c, h_c, w_e, h_e;
  logic [10:0] wm1_c, hm1_c;
  logic [9:0]  pxc_c, pyc_c;
  logic signed [15:0] g_lx, g_ly, g_rx, g_ry, g_nlx, g_nly, g_nrx, g_nry;
  always_comb begin
    w_e = {2'b00, eye_w_q};
    h_e = {2'b00, eye_h_q};
    w_c = (w_e < 13'd2) ? 13'd2 : ((w_e > MAX_DIM) ? MAX_DIM : w_e);
    h_c = (h_e < 13'd2) ? 13'd2 : ((h_e > MAX_DIM) ? MAX_DIM : h_e);
    wm1_c = 11'(w_c - 13'd1);
    hm1_c = 11'(h_c - 13'd1);
    pxc_c = ({1'b0, pix_x_q} > wm1_c) ? wm1_c[9:0] : pix_x_q;
    pyc_c = ({1'b0, pix_y_q} > hm1_c) ? hm1_c[9:0] : pix_y_q;
    g_lx = vf_q[0] ? lx_q : signed'({2'b00, pxc_c, 4'b0000});
    g_rx = vf_q[0] ? rx_q : signed'({2'b00, pxc_c, 4'b0000});
    g_ly = vf_q[0] ? ly_q : signed'({2'b00, pyc_c, 4'b0000});
    g_ry = vf_q[0] ? ry_q : signed'({2'b00, pyc_c, 4'b0000});
    g_nlx = vf_q[1] ? nlx_q : g_lx;
    g_nly = vf_q[1] ? nly_q : g_ly;
    g_nrx = vf_q[1] ? nrx_q : g_rx;
    g_nry = vf_q[1] ? nry_q : g_ry;
  end

  // Divider load operands per launch state
  logic              ld_go, ld_neg;
  logic [DIV_NW-1:0] ld_num;
  logic [DIV_DW-1:0] ld_den;
  logic [40:0]       dmag;
  logic [38:0]       xyn;
  always_comb begin
    ld_go  = 1'b0;
    ld_neg = 1'b0;
    ld_num = '0;
    ld_den = '0;
    dmag   = (num_q < 0) ? {(36'd0 - 36'(num_q)), 5'd0} : {36'(num_q), 5'd0};
    xyn    = '0;
    case (state_q)
      S_DL: begin
        ld_go  = (den_q != '0);
        ld_neg = (num_q < 0);
        ld_num = {dmag, 1'b0} + DIV_NW'(den_q);
        ld_den = {den_q, 1'b0};
      end
      S_ZL: begin
        ld_go  = (ad_q != '0) && (ad_q >= {17'd0, min_disp_q});
        ld_num = DIV_NW'({fb_q, 1'b0}) + DIV_NW'(ad_q);
        ld_den = DIV_DW'({ad_q, 1'b0});
      end
      S_XL: begin
        ld_go  = 1'b1;
        ld_neg = xneg_q;
        xyn    = {mx_q, 3'b000};
        ld_num = DIV_NW'({xyn, 1'b0}) + DIV_NW'(focal_q);
        ld_den = DIV_DW'({focal_q, 1'b0});
      end
      S_YL: begin
        ld_go  = 1'b1;
        ld_neg = yneg_q;
        xyn    = {my_q, 3'b000};
        ld_num = DIV_NW'({xyn, 1'b0}) + DIV_NW'(focal_q);
        ld_den = DIV_DW'({focal_q, 1'b0});
      end
      S_UL: begin
        ld_go  = 1'b1;
        ld_num = DIV_NW'({pxc_q, 17'd0}) + DIV_NW'(wm1_q);
        ld_den = DIV_DW'({wm1_q, 1'b0});
      end
      S_VL: begin
        ld_go  = 1'b1;
        ld_num = DIV_NW'({pyc_q, 17'd0}) + DIV_NW'(hm1_q);
        ld_den = DIV_DW'({hm1_q, 1'b0});
      end
      default: ;
    endcase
  end

  // One restoring divider step
  logic [DIV_DW:0]   dv_sh, dv_tr;
  logic              dv_bit, dv_done;
  always_comb begin
    dv_sh   = {dvr_q, dvn_q[DIV_NW-1]};
    dv_tr   = dv_sh - {1'b0, dvd_q};
    dv_bit  = !dv_tr[DIV_DW];
    dv_done = (dcnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (ld_go) begin
      dcnt_q <= DIV_CW'(DIV_NW);
    end else if (!dv_done) begin
      dcnt_q <= dcnt_q - DIV_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_go) begin
      dvn_q  <= ld_num;
      dvr_q  <= '0;
      dvd_q  <= ld_den;
      dneg_q <= ld_neg;
    end else if (!dv_done) begin
      dvn_q <= {dvn_q[DIV_NW-2:0], dv_bit};
      dvr_q <= dv_bit ? dv_tr[DIV_DW-1:0] : dv_sh[DIV_DW-1:0];
    end
  end

  // Disparity, offset and depth helpers
  logic signed [31:0] d_c;
  logic signed [32:0] diff_c;
  logic [DIV_NW-1:0]  zq_c;
  logic signed [12:0] xn_c, yn_c;
  always_comb begin
    d_c    = (den_q != '0) ? sat_q(dneg_q, dvn_q) : held_q;
    diff_c = 33'(d_c) - 33'(bias_q);
    zq_c   = (dvn_q < DIV_NW'(near_q)) ? DIV_NW'(near_q) : dvn_q;
    xn_c   = signed'({2'b00, pxc_q, 1'b0}) - signed'({2'b00, wm1_q});
    yn_c   = signed'({2'b00, hm1_q}) - signed'({2'b00, pyc_q, 1'b0});
  end

  // Sequencer state, output valid and held disparity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise the output item as the result moves out; drop it once taken
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_GEOM;
        S_GEOM: begin
          if (fs_q) held_q <= '0;
          state_q <= S_PROD;
        end
        S_PROD: state_q <= S_SUM;
        S_SUM:  state_q <= S_DL;
        S_DL:   state_q <= (den_q != '0) ? S_DW : S_DEP;
        S_DW:   if (dv_done) state_q <= S_DEP;
        S_DEP: begin
          held_q  <= d_c;
          state_q <= S_ZL;
        end
        S_ZL:   state_q <= ld_go ? S_ZW : S_XYM;
        S_ZW:   if (dv_done) state_q <= S_ZC;
        S_ZC:   state_q <= S_XYM;
        S_XYM:  state_q <= (focal_q == '0) ? S_UL : S_XL;
        S_XL:   state_q <= S_XW;
        S_XW:   if (dv_done) state_q <= S_YL;
        S_YL:   state_q <= S_YW;
        S_YW:   if (dv_done) state_q <= S_UL;
        S_UL:   state_q <= S_UW;
        S_UW:   if (dv_done) state_q <= S_VL;
        S_VL:   state_q <= S_VW;
        S_VW:   if (dv_done) state_q <= S_OUT;
        S_OUT:  if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fs_q    <= frame_start_i;
          pix_x_q <= pixel_x_i;
          pix_y_q <= pixel_y_i;
          lx_q    <= left_x_i;
          ly_q    <= left_y_i;
          rx_q    <= right_x_i;
          ry_q    <= right_y_i;
          nlx_q   <= next_left_x_i;
          nly_q   <= next_left_y_i;
          nrx_q   <= next_right_x_i;
          nry_q   <= next_right_y_i;
          vf_q    <= valid_flags_i;
        end
      end
      S_GEOM: begin
        pxc_q <= pxc_c;
        pyc_q <= pyc_c;
        wm1_q <= wm1_c;
        hm1_q <= hm1_c;
        tx_q  <= (18'(g_nlx) + 18'(g_nrx)) - (18'(g_lx) + 18'(g_rx));
        ty_q  <= (18'(g_nly) + 18'(g_nry)) - (18'(g_ly) + 18'(g_ry));
        dx_q  <= 17'(g_lx) - 17'(g_rx);
        dy_q  <= 17'(g_ly) - 17'(g_ry);
      end
      S_PROD: begin
        pxx_q <= 36'(tx_q * tx_q);
        pyy_q <= 36'(ty_q * ty_q);
        pxd_q <= 36'(tx_q * 18'(dx_q));
        pyd_q <= 36'(ty_q * 18'(dy_q));
        fb_q  <= focal_q * base_q;
      end
      S_SUM: begin
        den_q <= 36'(pxx_q) + 36'(pyy_q);
        num_q <= pxd_q + pyd_q;
      end
      S_DEP: ad_q <= diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
      S_ZL:  if (!ld_go) z_q <= far_q;
      S_ZC:  z_q <= (zq_c > DIV_NW'(far_q)) ? far_q : zq_c[23:0];
      S_XYM: begin
        // magnitudes times depth; sign travels alongside
        xneg_q  <= xn_c[12];
        yneg_q  <= yn_c[12];
        mx_q    <= 36'((xn_c[12] ? 12'(-xn_c) : 12'(xn_c)) * z_q);
        my_q    <= 36'((yn_c[12] ? 12'(-yn_c) : 12'(yn_c)) * z_q);
        res_x_q <= '0;
        res_y_q <= '0;
      end
      S_XW: if (dv_done) res_x_q <= sat_q(dneg_q, dvn_q);
      S_YW: if (dv_done) res_y_q <= sat_q(dneg_q, dvn_q);
      S_UW: if (dv_done) res_u_q <= dvn_q[16:0];
      S_VW: if (dv_done) res_v_q <= dvn_q[16:0];
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          pos_x_o <= res_x_q;
          pos_y_o <= res_y_q;
          pos_z_o <= signed'(32'd0 - ({8'd0, z_q} + BASE_D));
          tex_u_o <= res_u_q;
          tex_v_o <= res_v_q;
        end
      end
      default: ;
    endcase
  end

  // Divider is idle whenever the sequencer waits for an item
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (dcnt_q == '0))
    else $error("divider busy while idle");

  // An accepted item closes the input until its result is done
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input open during work");

  // A finished item waits while the output slot is still full
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("finished item dropped");

endmodule
`default_nettype wire

/* tb/tb_stereo_disparity_depth_vertex.sv */
// Testbench for the stereo disparity to depth vertex block, with a scoreboard that predicts each item.
`timescale 1ns / 100ps
module tb_stereo_disparity_depth_vertex
  import sddv_pkg::*;
();

  localparam int    CLK_HALF   = 10;
  localparam int    RST_CYCLES = 5;
  localparam int    DRAIN_WAIT = 300;
  localparam int    HOLD_LEN   = 2000;
  localparam int    PHASE_LEN  = 305;
  localparam longint BASE_DIST = 65536;
  localparam longint EYE_MAX   = 1024;
  localparam int    CYCLE_LIMIT = 3000000;
  localparam int    VF_HERE = 0;
  localparam int    VF_NEXT = 1;

  typedef struct {
    logic               frame_start;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [15:0] left_x, left_y, right_x, right_y;
    logic signed [15:0] next_left_x, next_left_y, next_right_x, next_right_y;
    logic [1:0]         valid_flags;
  } vertex_t;

  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z;
    logic [16:0] tex_u, tex_v;
  } vertex_out_t;

  // Scoreboard: predicts the vertex output and checks it against the block
  class depth_scoreboard;
    longint eye_w, eye_h, focal, base_len, bias, min_disp, near_d, far_d;
    longint held_disp;
    vertex_out_t pending[$];
    int errors;
    int checked;

    function new();
      eye_w = RST_EYE_WIDTH; eye_h = RST_EYE_HEIGHT; focal = RST_FOCAL;
      base_len = RST_BASELINE; bias = 0; min_disp = RST_MIN_DISP;
      near_d = RST_NEAR; far_d = RST_FAR; held_disp = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        REG_EYE_WIDTH:  eye_w = data[10:0];
        REG_EYE_HEIGHT: eye_h = data[10:0];
        REG_FOCAL:      focal = data[15:0];
        REG_BASELINE:   base_len = data[15:0];
        REG_DISP_BIAS:  bias = longint'($signed(data[15:0]));
        REG_MIN_DISP:   min_disp = data[15:0];
        REG_NEAR:       near_d = data;
        REG_FAR:        far_d = data;
        default: ;
      endcase
    endfunction

    function longint div_near(longint num, longint den);
      return (2 * num + den) / (2 * den);
    endfunction

    // Ties round away from zero
    function longint sdiv_near(longint num, longint den);
      longint q;
      q = div_near(num < 0 ? -num : num, den);
      return num < 0 ? -q : q;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp_dim(longint v);
      return v < 2 ? 2 : (v > EYE_MAX ? EYE_MAX : v);
    endfunction

    function void note_vertex(vertex_t v);
      longint w, h, px, py, lx, ly, rx, ry, nlx, nly, nrx, nry;
      longint tx, ty, dx, dy, den, num, d, diff, ad, z, xn, yn, xq, yq;
      vertex_out_t r;
      w = clamp_dim(eye_w);
      h = clamp_dim(eye_h);
      px = v.pixel_x; py = v.pixel_y;
      if (px > w - 1) px = w - 1;
      if (py > h - 1) py = h - 1;
      if (v.frame_start) held_disp = 0;
      lx = v.left_x; ly = v.left_y; rx = v.right_x; ry = v.right_y;
      // Fall back to the pixel position for an invalid point
      if (!v.valid_flags[VF_HERE]) begin
        lx = px * 16; rx = lx; ly = py * 16; ry = ly;
      end
      nlx = v.next_left_x; nly = v.next_left_y;
      nrx = v.next_right_x; nry = v.next_right_y;
      if (!v.valid_flags[VF_NEXT]) begin
        nlx = lx; nly = ly; nrx = rx; nry = ry;
      end
      // Project eye difference onto the tangent; hold on a degenerate one
      tx = (nlx + nrx) - (lx + rx);
      ty = (nly + nry) - (ly + ry);
      dx = lx - rx; dy = ly - ry;
      den = tx * tx + ty * ty;
      d = held_disp;
      if (den > 0) begin
        num = tx * dx + ty * dy;
        d = sat32(sdiv_near(num * 32, den));
      end
      held_disp = d;
      // Depth with minimum disparity and near/far clamp
      diff = d - bias;
      ad = diff < 0 ? -diff : diff;
      z = far_d;
      if (ad != 0 && ad >= min_disp) begin
        z = div_near(focal * base_len, ad);
        if (z < near_d) z = near_d;
        if (z > far_d) z = far_d;
      end
      xq = 0; yq = 0;
      if (focal != 0) begin
        xn = 2 * px - (w - 1);
        yn = (h - 1) - 2 * py;
        xq = sat32(sdiv_near(xn * z * 8, focal));
        yq = sat32(sdiv_near(yn * z * 8, focal));
      end
      r.pos_x = 32'(xq);
      r.pos_y = 32'(yq);
      r.pos_z = 32'(-(z + BASE_DIST));
      r.tex_u = 17'(div_near(px * 65536, w - 1));
      r.tex_v = 17'(div_near(py * 65536, h - 1));
      pending = {pending, r};
    endfunction

    function void check_result(vertex_out_t got);
      vertex_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected output item: pos_x %h pos_y %h", got.pos_x, got.pos_y);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x expected %h actual %h", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y expected %h actual %h", e.pos_y, got.pos_y); errors++;
      end
      if (got.pos_z !== e.pos_z) begin
        $error("pos_z expected %h actual %h", e.pos_z, got.pos_z); errors++;
      end
      if (got.tex_u !== e.tex_u) begin
        $error("tex_u expected %h actual %h", e.tex_u, got.tex_u); errors++;
      end
      if (got.tex_v !== e.tex_v) begin
        $error("tex_v expected %h actual %h", e.tex_v, got.tex_v); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic frame_start_i = 1'b0;
  logic [9:0] pixel_x_i = '0, pixel_y_i = '0;
  logic signed [15:0] left_x_i = '0, left_y_i = '0, right_x_i = '0, right_y_i = '0;
  logic signed [15:0] next_left_x_i = '0, next_left_y_i = '0;
  logic signed [15:0] next_right_x_i = '0, next_right_y_i = '0;
  logic [1:0] valid_flags_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;

  depth_scoreboard sb = new();
  int  cycle_cnt = 0;
  int  sent_cnt = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  stereo_disparity_depth_vertex u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .frame_start_i, .pixel_x_i, .pixel_y_i,
    .left_x_i, .left_y_i, .right_x_i, .right_y_i,
    .next_left_x_i, .next_left_y_i, .next_right_x_i, .next_right_y_i,
    .valid_flags_i, .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .tex_u_o, .tex_v_o
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_stereo_disparity_depth_vertex: FAIL");
      $finish;
    end
  end

  // Check each output item at the falling edge before its handshake edge
  always @(negedge clk_i) begin
    vertex_out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pos_x = pos_x_o; got.pos_y = pos_y_o; got.pos_z = pos_z_o;
      got.tex_u = tex_u_o; got.tex_v = tex_v_o;
      sb.check_result(got);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one register write and hold it until accepted; the caller drops valid
  task automatic write_cfg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Offer one item and hold it until accepted; valid stays high afterwards unless a random gap follows
  task automatic send_vertex(vertex_t v);
    in_valid_i     <= 1'b1;
    frame_start_i  <= v.frame_start;
    pixel_x_i      <= v.pixel_x;       pixel_y_i      <= v.pixel_y;
    left_x_i       <= v.left_x;        left_y_i       <= v.left_y;
    right_x_i      <= v.right_x;       right_y_i      <= v.right_y;
    next_left_x_i  <= v.next_left_x;   next_left_y_i  <= v.next_left_y;
    next_right_x_i <= v.next_right_x;  next_right_y_i <= v.next_right_y;
    valid_flags_i  <= v.valid_flags;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note_vertex(v);
    sent_cnt++;
    // Insert a random gap after the item
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Pause the sender until every expected item has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic vertex_t make_vertex(bit fs, int px, int py, int lx, int ly, int rx,
                                          int ry, int nlx, int nly, int nrx, int nry,
                                          int flags);
    vertex_t v;
    v.frame_start = fs; v.pixel_x = 10'(px); v.pixel_y = 10'(py);
    v.left_x = 16'(lx); v.left_y = 16'(ly); v.right_x = 16'(rx); v.right_y = 16'(ry);
    v.next_left_x = 16'(nlx); v.next_left_y = 16'(nly);
    v.next_right_x = 16'(nrx); v.next_right_y = 16'(nry);
    v.valid_flags = 2'(flags);
    return v;
  endfunction

  // Mostly plausible geometry with random content; some pure noise
  function automatic vertex_t rand_vertex();
    vertex_t v;
    int lx, ly, disp, sx, sy;
    if ($urandom_range(0, 9) < 2) begin
      v.frame_start = 1'($urandom); v.pixel_x = 10'($urandom); v.pixel_y = 10'($urandom);
      v.left_x = 16'($urandom); v.left_y = 16'($urandom);
      v.right_x = 16'($urandom); v.right_y = 16'($urandom);
      v.next_left_x = 16'($urandom); v.next_left_y = 16'($urandom);
      v.next_right_x = 16'($urandom); v.next_right_y = 16'($urandom);
      v.valid_flags = 2'($urandom);
      return v;
    end
    v.frame_start = ($urandom_range(0, 19) == 0);
    v.pixel_x = 10'($urandom_range(0, 1023));
    v.pixel_y = 10'($urandom_range(0, 1023));
    lx = $urandom_range(0, 16000) - 8000;
    ly = $urandom_range(0, 16000) - 8000;
    disp = $urandom_range(0, 1600) - 200;
    sx = $urandom_range(0, 8) == 0 ? 0 : $urandom_range(0, 400) - 100;
    sy = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 60) - 30;
    v.left_x = 16'(lx); v.left_y = 16'(ly);
    v.right_x = 16'(lx - disp); v.right_y = 16'(ly + $urandom_range(0, 8) - 4);
    v.next_left_x = 16'(lx + sx); v.next_left_y = 16'(ly + sy);
    v.next_right_x = 16'(lx - disp + sx + $urandom_range(0, 8) - 4);
    v.next_right_y = 16'(v.right_y + sy);
    v.valid_flags = $urandom_range(0, 5) == 0 ? 2'($urandom_range(0, 2)) : 2'd3;
    return v;
  endfunction

  initial begin
    logic [23:0] phase_cfg [5][8];
    int phase_items;
    // Settings per phase: normal, extremes, opposite extremes, zero focal, random
    phase_cfg[0] = '{24'd640, 24'd480, 24'd9000, 24'd8000, 24'hFFF0, 24'd16,
                     24'd3000, 24'd2621440};
    phase_cfg[1] = '{24'd0, 24'd2047, 24'd16, 24'd65535, 24'h8000, 24'd0,
                     24'hFFFFFF, 24'd0};
    phase_cfg[2] = '{24'd1024, 24'd2, 24'd65535, 24'd0, 24'h7FFF, 24'hFFFF,
                     24'd0, 24'hFFFFFF};
    phase_cfg[3] = '{24'd1, 24'd1, 24'd0, 24'd30000, 24'd8, 24'd1,
                     24'd100, 24'd900000};
    for (int k = 0; k < 8; k++) phase_cfg[4][k] = 24'($urandom);
    phase_cfg[4][0] = 24'($urandom_range(2, 1024));
    phase_cfg[4][1] = 24'($urandom_range(2, 1024));

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at reset settings
    send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_vertex(make_vertex(1, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_vertex(make_vertex(0, 100, 50, 1600, 800, 1440, 800, 1616, 800, 1456, 800, 3));
    send_vertex(make_vertex(0, 101, 50, 1600, 800, 1440, 800, 0, 0, 0, 0, 1));
    send_vertex(make_vertex(0, 102, 50, 5, 5, 5, 5, 1616, 800, 1456, 800, 2));
    send_vertex(make_vertex(1, 103, 51, 7, 7, 7, 7, 0, 0, 0, 0, 1));
    send_vertex(make_vertex(0, 383, 223, 32767, 32767, -32768, -32768,
                            -32768, -32768, 32767, 32767, 3));
    send_vertex(make_vertex(0, 0, 223, -32768, 32767, 32767, -32768,
                            32767, -32768, -32768, 32767, 3));
    send_vertex(make_vertex(0, 200, 100, 800, 800, 800, 800, 816, 800, 816, 800, 3));
    send_vertex(make_vertex(0, 383, 0, 800, 800, 799, 800, 1800, 800, 1799, 800, 3));
    send_vertex(make_vertex(0, 10, 10, 100, 100, 50, 90, 100, 116, 50, 106, 3));
    send_vertex(make_vertex(0, 512, 700, -16, -16, -400, -20, 200, 0, -180, -4, 3));
    send_vertex(make_vertex(1, 1000, 300, 32767, 0, -32768, 0, 32767, 1, -32768, 1, 3));
    send_vertex(make_vertex(0, 383, 223, 4000, 4000, 3990, 4000, 4000, 4000, 3990, 4000, 2));
    drain();

    // Default settings with a long receiver hold-off, then the other phases
    hold_req = 1'b1;
    for (int i = 0; i < PHASE_LEN; i++) send_vertex(rand_vertex());
    drain();
    for (int p = 0; p < 5; p++) begin
      for (int k = 0; k < 8; k++) write_cfg(k[2:0], phase_cfg[p][k]);
      cfg_valid_i <= 1'b0;
      phase_items = PHASE_LEN;
      for (int i = 0; i < phase_items; i++) begin
        if (p == 4 && i == phase_items / 2) no_idle = 1'b1;
        send_vertex(rand_vertex());
      end
      drain();
    end

    $display("Sent %0d vertices over six register settings, checked %0d outputs.",
             sent_cnt, sb.checked);
    $display("Covered fallback, held disparity, clamps, zero focal and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_stereo_disparity_depth_vertex: PASS");
    end else begin
      $display("tb_stereo_disparity_depth_vertex: FAIL");
    end
    $finish;
  end

endmodule
